[hdl/aed_pkg.sv]
// Package for the attenuated Euclidean distance block.
// Holds beat types, controller/datapath command and status structs, and constants.
// No dependencies.
package aed_pkg;

   // Element width range and default (Q8.8 at the default)
   localparam int ElemWidthDefault = 16;
   localparam int FieldWidth       = 16;
   localparam int DistWidth        = 64;

   // Square root unit: one result bit per step
   localparam int RootSteps    = DistWidth / 2;
   localparam int RootCntWidth = $clog2(RootSteps);
   localparam logic [DistWidth-1:0] RootBitInit = DistWidth'(1) << (DistWidth - 2);

   // Register port
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam logic CsrIdxSkipRoot = 1'b0;

   // Input beat
   typedef struct packed {
      logic signed [FieldWidth-1:0] elem_a;
      logic signed [FieldWidth-1:0] elem_b;
      logic                         last_elem;
   } aed_req_type;

   // Result beat
   typedef struct packed {
      logic [DistWidth-1:0] distance;
      logic                 overflowed;
   } aed_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load_in;
      logic mul_first;
      logic mul_second;
      logic accumulate;
      logic root_start;
      logic root_step;
      logic out_load;
   } aed_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_elem;
   } aed_status_type;

endpackage

[hdl/aed_ctrl.sv]
// Controller state machine for the attenuated Euclidean distance block.
// Sequences multiply, accumulate, square root and result load. Uses aed_pkg.
module aed_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    skip_root,
   input  aed_pkg::aed_status_type status,
   output aed_pkg::aed_cmd_type    cmd
);
   import aed_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_ACC,
      ST_ROOT,
      ST_FIN
   } state_type;

   state_type               state_ff, state_in;
   logic [RootCntWidth-1:0] cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            cmd.mul_first = 1'b1;
            state_in      = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_second = 1'b1;
            state_in       = ST_ACC;
         end
         ST_ACC: begin
            cmd.accumulate = 1'b1;
            priority if (!status.last_elem) begin
               state_in = ST_IDLE;
            end else if (skip_root) begin
               state_in = ST_FIN;
            end else begin
               cmd.root_start = 1'b1;
               cnt_in         = '0;
               state_in       = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == RootCntWidth'(RootSteps - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // output register must be free or draining this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result beat valid: set on load, cleared when taken
   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/aed_dp.sv]
// Datapath for the attenuated Euclidean distance block: multipliers,
// saturating accumulator, bit-pair square root unit, result register. Uses aed_pkg.
module aed_dp #(
   parameter int ELEM_WIDTH = aed_pkg::ElemWidthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  aed_pkg::aed_req_type    req_data,
   input  logic                    skip_root,
   input  aed_pkg::aed_cmd_type    cmd,
   output aed_pkg::aed_status_type status,
   output aed_pkg::aed_rsp_type    rsp_data
);
   import aed_pkg::*;

   localparam int ProdWidth = 2 * ELEM_WIDTH;
   localparam int TermWidth = 4 * ELEM_WIDTH;

   logic signed [ELEM_WIDTH-1:0] a_ff, b_ff;
   logic                         last_ff;
   logic        [ELEM_WIDTH-1:0] a_mag, b_mag, d_mag;
   logic signed [ELEM_WIDTH:0]   diff;
   logic        [ProdWidth-1:0]  prod_ab_ff, prod_dd_ff;
   logic        [TermWidth-1:0]  term_ff;
   logic        [DistWidth:0]    sum_wide;
   logic        [DistWidth-1:0]  sum_ff, sum_next;
   logic                         sat_ff, sat_next;
   logic        [DistWidth-1:0]  rem_ff, res_ff, bit_ff, trial;
   logic        [DistWidth-1:0]  dist_ff;
   logic                         ovf_ff;

   // Input capture, low ELEM_WIDTH bits of each element
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         a_ff    <= req_data.elem_a[ELEM_WIDTH-1:0];
         b_ff    <= req_data.elem_b[ELEM_WIDTH-1:0];
         last_ff <= req_data.last_elem;
      end
   end

   // Magnitudes; the most negative value maps to 2^(W-1) as unsigned bits
   assign diff  = {a_ff[ELEM_WIDTH-1], a_ff} - {b_ff[ELEM_WIDTH-1], b_ff};
   assign a_mag = a_ff[ELEM_WIDTH-1] ? ELEM_WIDTH'(-a_ff) : ELEM_WIDTH'(a_ff);
   assign b_mag = b_ff[ELEM_WIDTH-1] ? ELEM_WIDTH'(-b_ff) : ELEM_WIDTH'(b_ff);
   assign d_mag = diff[ELEM_WIDTH] ? ELEM_WIDTH'(-diff) : ELEM_WIDTH'(diff);

   // Two multiply stages, registered between
   always_ff @(posedge clock) begin
      if (cmd.mul_first) begin
         prod_ab_ff <= a_mag * b_mag;
         prod_dd_ff <= d_mag * d_mag;
      end
      if (cmd.mul_second) begin
         term_ff <= prod_ab_ff * prod_dd_ff;
      end
   end

   // Saturating add
   assign sum_wide = {1'b0, sum_ff} + (DistWidth + 1)'(term_ff);
   assign sum_next = sum_wide[DistWidth] ? '1 : sum_wide[DistWidth-1:0];
   assign sat_next = sat_ff | sum_wide[DistWidth];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         sat_ff <= 1'b0;
      end else if (cmd.out_load) begin
         sum_ff <= '0;
         sat_ff <= 1'b0;
      end else if (cmd.accumulate) begin
         sum_ff <= sum_next;
         sat_ff <= sat_next;
      end
   end

   // Floor square root, one result bit per step
   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.root_start) begin
         rem_ff <= sum_next;
         res_ff <= '0;
         bit_ff <= RootBitInit;
      end else if (cmd.root_step) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         dist_ff <= skip_root ? sum_ff : res_ff;
         ovf_ff  <= sat_ff;
      end
   end

   assign status.last_elem    = last_ff;
   assign rsp_data.distance   = dist_ff;
   assign rsp_data.overflowed = ovf_ff;

endmodule

[hdl/attenuated_euclidean_distance.sv]
// Attenuated Euclidean distance top level: register port, controller, datapath.
// Depends on aed_pkg, aed_ctrl and aed_dp.
//
// Each input beat carries one element pair (signed Q8.8) and a last flag; the block
// adds |a|*|b|*(a-b)^2 into a saturating Q32.32 sum and, on the last pair, returns one
// result beat: the raw sum when skip_root (offset 0x0, bit 0) is 1, else its floor
// square root in Q16.16, plus a sticky overflow flag. A non-last pair passes through
// capture, two registered multiply stages and accumulate. A last pair then goes on to
// the result load with skip_root set, or first to the root, which the single square
// root unit builds one result bit per cycle. The result sits in an output register, so
// the next vector's pairs are taken while it waits; a further last pair waits there
// until the previous result beat has been taken.
module attenuated_euclidean_distance #(
   parameter int ELEM_WIDTH = aed_pkg::ElemWidthDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  aed_pkg::aed_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output aed_pkg::aed_rsp_type                 rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [aed_pkg::CsrAddrWidth-1:0]     paddr,
   input  logic [aed_pkg::CsrDataWidth-1:0]     pwdata,
   output logic [aed_pkg::CsrDataWidth-1:0]     prdata,
   output logic                                 pready
);
   import aed_pkg::*;

   logic           skip_root_ff;
   logic           csr_write;
   aed_cmd_type    cmd;
   aed_status_type status;

   // Register port, single register at word 0
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[CsrAddrWidth-1] == CsrIdxSkipRoot);
   assign prdata    = (paddr[CsrAddrWidth-1] == CsrIdxSkipRoot)
                      ? CsrDataWidth'(skip_root_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_root_ff <= 1'b0;
      end else if (csr_write) begin
         skip_root_ff <= pwdata[0];
      end
   end

   aed_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .skip_root (skip_root_ff),
      .status    (status),
      .cmd       (cmd)
   );

   aed_dp #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .skip_root (skip_root_ff),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // One pair at a time: an accepted beat closes the input until its work is done
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while a pair is still in work");

   // A saturated raw sum reads as all ones
   a_sat_raw: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflowed && skip_root_ff) |-> (rsp_data.distance == '1))
      else $error("saturated raw sum is not all ones");

   // The root of a saturated sum is the largest 32-bit root
   a_sat_root: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflowed && !skip_root_ff)
         |-> (rsp_data.distance == 64'h0000_0000_FFFF_FFFF))
      else $error("root of saturated sum is wrong");
`endif

endmodule
